// ----- hdl/fqd_pkg.sv -----
// Shared types and constants for the FIFO queue with dump.
`timescale 1ns / 1ps

package fqd_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_FRONT = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_DUMP  = 3'd4
  } fqd_cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } fqd_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } fqd_state_t;

endpackage

// ----- hdl/fqd_channels.sv -----
// Valid/ready channel interfaces for the command input and the result output.
`timescale 1ns / 1ps

interface fqd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface fqd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_res;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

// ----- hdl/fifo_queue_with_dump.sv -----
// Top level of the FIFO queue with dump: ring memory, pointers and command sequencer.
`timescale 1ns / 1ps

// A queue of signed 32-bit values held in a DEPTH-entry ring memory with one
// registered read port. Push returns nothing unless the queue is full. For
// pop and front, the head is read in the cycle the command is accepted and
// reaches the output register in the next one. Dump streams one element per
// cycle while the output is not held off, paced by the single read port,
// with last set on the tail element; no command is accepted until the final
// element has been loaded. Commands that only return a status (full push;
// pop, front, clear or dump on an empty queue) do not enter the read state.
// A held-off output stalls the sequencer without losing data. The memory
// needs no clearing after reset: only occupied slots are ever read.
module fifo_queue_with_dump #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  fqd_in_if.sink    in_ch,
  fqd_out_if.source out_ch
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fqd_pkg::fqd_state_t state_r, state_nxt;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [31:0]          out_value_r, out_value_nxt;
  fqd_pkg::fqd_status_t        out_status_r, out_status_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [fqd_pkg::DATA_W-1:0]  mem [DEPTH];
  logic [fqd_pkg::DATA_W-1:0]  rd_data_r;
  logic                        wr_en;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;

  logic out_free;
  logic accept;
  logic is_empty;
  logic is_full;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
    return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_empty = (fill_r == '0);
  assign is_full  = (fill_r == CW'(DEPTH));

  // Ring memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= in_ch.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fqd_pkg::ST_IDLE: begin
        if (accept && !is_empty &&
            (in_ch.cmd inside {fqd_pkg::CMD_POP, fqd_pkg::CMD_FRONT, fqd_pkg::CMD_DUMP})) begin
          state_nxt = fqd_pkg::ST_READ;
        end
      end
      fqd_pkg::ST_READ: begin
        if (out_free && (rem_r == '0)) begin
          state_nxt = fqd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fqd_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and datapath updates.
  always_comb begin
    in_ch.ready    = (state_r == fqd_pkg::ST_IDLE) && out_free;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    rd_idx_nxt     = rd_idx_r;
    rem_nxt        = rem_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      fqd_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            fqd_pkg::CMD_PUSH: begin
              if (is_full) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = fqd_pkg::STATUS_FULL;
                out_last_nxt   = 1'b1;
              end else begin
                wr_en    = 1'b1;
                tail_nxt = wrap_inc(tail_r);
                fill_nxt = fill_r + 1'b1;
              end
            end
            fqd_pkg::CMD_POP, fqd_pkg::CMD_FRONT, fqd_pkg::CMD_CLEAR,
            fqd_pkg::CMD_DUMP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = fqd_pkg::STATUS_EMPTY;
                out_last_nxt   = 1'b1;
              end else if (in_ch.cmd == fqd_pkg::CMD_CLEAR) begin
                head_nxt = '0;
                tail_nxt = '0;
                fill_nxt = '0;
              end else begin
                rd_en   = 1'b1;
                rem_nxt = '0;
                if (in_ch.cmd == fqd_pkg::CMD_POP) begin
                  head_nxt = wrap_inc(head_r);
                  fill_nxt = fill_r - 1'b1;
                end else if (in_ch.cmd == fqd_pkg::CMD_DUMP) begin
                  rd_idx_nxt = wrap_inc(head_r);
                  rem_nxt    = fill_r - 1'b1;
                end
              end
            end
            default: begin
              // Unused command codes are dropped without effect.
            end
          endcase
        end
      end
      fqd_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_data_r;
          out_status_nxt = fqd_pkg::STATUS_OK;
          out_last_nxt   = (rem_r == '0);
          // Issue the next dump read as the current element leaves.
          if (rem_r != '0) begin
            rd_en      = 1'b1;
            rd_addr    = rd_idx_r;
            rd_idx_nxt = wrap_inc(rd_idx_r);
            rem_nxt    = rem_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqd_pkg::ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count exceeds queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !is_full)
    else $error("ring write while queue is full");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_empty && (in_ch.cmd == fqd_pkg::CMD_POP)) |=>
      (state_r == fqd_pkg::ST_READ) && !in_ch.ready)
    else $error("pop transaction did not enter the read state");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the FIFO queue with dump: directed, back-pressure and random traffic.
`timescale 1ns / 1ps

module tb_top;

  localparam int QDEPTH      = fqd_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  // Command codes that the block must ignore.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    logic signed [31:0]   value;
    fqd_pkg::fqd_status_t status;
    logic                 last;
  } q_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fqd_in_if  in_ch ();
  fqd_out_if out_ch ();

  fifo_queue_with_dump #(.DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the queue, updated as each transaction is accepted.
  logic signed [31:0] shadow_mem [QDEPTH];
  int shadow_head  = 0;
  int shadow_tail  = 0;
  int shadow_count = 0;
  q_result_t expected_q [$];

  int errors     = 0;
  int printed    = 0;
  int cycle_cnt  = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_ok       = 0;
  int n_empty    = 0;
  int n_full     = 0;
  int n_dumps    = 0;
  int max_fill   = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_go        = 1'b0;
  bit hold_seen      = 1'b0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (printed < MAX_PRINTED) begin
      printed++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  task automatic queue_expected(input logic signed [31:0] v,
                                input fqd_pkg::fqd_status_t st, input logic lst);
    q_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    expected_q.push_back(r);
  endtask

  task automatic predict_cmd(input logic [2:0] c, input logic signed [31:0] v);
    int idx;
    n_items++;
    case (c)
      fqd_pkg::CMD_PUSH: begin
        if (shadow_count == QDEPTH) begin
          queue_expected('0, fqd_pkg::STATUS_FULL, 1'b1);
        end else begin
          shadow_mem[shadow_tail] = v;
          shadow_tail = (shadow_tail + 1) % QDEPTH;
          shadow_count++;
          if (shadow_count > max_fill) max_fill = shadow_count;
        end
      end
      fqd_pkg::CMD_POP, fqd_pkg::CMD_FRONT, fqd_pkg::CMD_CLEAR, fqd_pkg::CMD_DUMP: begin
        if (shadow_count == 0) begin
          queue_expected('0, fqd_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          case (c)
            fqd_pkg::CMD_POP: begin
              queue_expected(shadow_mem[shadow_head], fqd_pkg::STATUS_OK, 1'b1);
              shadow_head = (shadow_head + 1) % QDEPTH;
              shadow_count--;
            end
            fqd_pkg::CMD_FRONT: begin
              queue_expected(shadow_mem[shadow_head], fqd_pkg::STATUS_OK, 1'b1);
            end
            fqd_pkg::CMD_CLEAR: begin
              shadow_head  = 0;
              shadow_tail  = 0;
              shadow_count = 0;
            end
            default: begin
              n_dumps++;
              idx = shadow_head;
              for (int i = 0; i < shadow_count; i++) begin
                queue_expected(shadow_mem[idx], fqd_pkg::STATUS_OK, (i == shadow_count - 1));
                idx = (idx + 1) % QDEPTH;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Valid is left high after a transaction; it is lowered only by an idle gap
  // or by a drain, so it never sees two updates in one time step.
  task automatic send_cmd(input logic [2:0] c, input logic signed [31:0] v);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd   <= 3'($urandom);
      in_ch.value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_cmd(c, v);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct  <= s_pct;
    recv_stall_pct <= r_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_cmd(fqd_pkg::CMD_POP, '0);
    send_cmd(fqd_pkg::CMD_FRONT, '0);
    send_cmd(fqd_pkg::CMD_CLEAR, '0);
    send_cmd(fqd_pkg::CMD_DUMP, '1);
    send_cmd(fqd_pkg::CMD_PUSH, 32'h8000_0000);
    send_cmd(fqd_pkg::CMD_PUSH, 32'h7FFF_FFFF);
    send_cmd(fqd_pkg::CMD_PUSH, '0);
    send_cmd(fqd_pkg::CMD_PUSH, '1);
    send_cmd(fqd_pkg::CMD_PUSH, 32'h5A5A_A5A5);
    send_cmd(fqd_pkg::CMD_FRONT, '0);
    send_cmd(fqd_pkg::CMD_DUMP, '0);
    send_cmd(fqd_pkg::CMD_POP, '0);
    send_cmd(fqd_pkg::CMD_FRONT, '0);
    send_cmd(CMD_RSVD_5, 32'h1234_5678);
    send_cmd(CMD_RSVD_6, '1);
    send_cmd(CMD_RSVD_7, 32'h8000_0000);
    send_cmd(fqd_pkg::CMD_DUMP, '0);
    send_cmd(fqd_pkg::CMD_CLEAR, '0);
    send_cmd(fqd_pkg::CMD_DUMP, '0);
    send_cmd(fqd_pkg::CMD_POP, '0);
    send_cmd(fqd_pkg::CMD_PUSH, 32'h0000_0001);
    send_cmd(fqd_pkg::CMD_POP, '0);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while pushes keep coming, so the
  // queue fills, a full status sits in the output and the input stalls.
  task automatic test_fill_under_backpressure();
    set_idling(0, 0);
    send_cmd(fqd_pkg::CMD_CLEAR, '0);
    hold_go <= ~hold_go;
    repeat (QDEPTH + 4) send_cmd(fqd_pkg::CMD_PUSH, pick_value());
    send_cmd(fqd_pkg::CMD_DUMP, '0);
    send_cmd(fqd_pkg::CMD_POP, '0);
    send_cmd(fqd_pkg::CMD_POP, '0);
    send_cmd(fqd_pkg::CMD_FRONT, '0);
    send_cmd(fqd_pkg::CMD_PUSH, pick_value());
    send_cmd(fqd_pkg::CMD_DUMP, '0);
    drain_results();
  endtask

  // Alternates between filling the queue up to full and draining it to empty,
  // with random content and occasional clears and ignored codes.
  task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
    int sent;
    int r;
    bit filling;
    logic [2:0] c;
    set_idling(s_pct, r_pct);
    sent = 0;
    filling = 1'b1;
    while (sent < count) begin
      if (filling && shadow_count == QDEPTH && $urandom_range(3) == 0) filling = 1'b0;
      if (!filling && shadow_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (filling) begin
        if (r < 70)      c = fqd_pkg::CMD_PUSH;
        else if (r < 81) c = fqd_pkg::CMD_POP;
        else if (r < 87) c = fqd_pkg::CMD_FRONT;
        else if (r < 94) c = fqd_pkg::CMD_DUMP;
        else if (r < 95) c = fqd_pkg::CMD_CLEAR;
        else             c = 3'(CMD_RSVD_5 + $urandom_range(2));
      end else begin
        if (r < 25)      c = fqd_pkg::CMD_PUSH;
        else if (r < 65) c = fqd_pkg::CMD_POP;
        else if (r < 75) c = fqd_pkg::CMD_FRONT;
        else if (r < 88) c = fqd_pkg::CMD_DUMP;
        else if (r < 93) c = fqd_pkg::CMD_CLEAR;
        else             c = 3'(CMD_RSVD_5 + $urandom_range(2));
      end
      send_cmd(c, pick_value());
      if (c <= fqd_pkg::CMD_DUMP) sent++;
    end
    drain_results();
  endtask

  always @(posedge clk) begin : rx_side
    q_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      case (out_ch.status)
        fqd_pkg::STATUS_OK:    n_ok++;
        fqd_pkg::STATUS_EMPTY: n_empty++;
        default:               n_full++;
      endcase
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0b",
                                  out_ch.value_res, out_ch.status, out_ch.last));
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.value_res !== exp_r.value)
          report_mismatch($sformatf("value_res %0d, expected %0d",
                                    out_ch.value_res, exp_r.value));
        if (out_ch.status !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, exp_r.status));
        if (out_ch.last !== exp_r.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, exp_r.last));
      end
    end
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = '0;
    in_ch.value  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_under_backpressure();
    test_random_traffic(0, 0, 70);
    test_random_traffic(59, 0, 70);
    test_random_traffic(0, 59, 70);
    test_random_traffic(13, 13, 70);

    while (expected_q.size() != 0) begin
      exp_check_leftover : begin
        report_mismatch($sformatf("expected result never arrived, value %0d status %0d",
                                  expected_q[0].value, expected_q[0].status));
        void'(expected_q.pop_front());
      end
    end

    $display("Ran %0d commands giving %0d results: %0d data, %0d empty, %0d full; %0d dumps.",
             n_items, n_results, n_ok, n_empty, n_full, n_dumps);
    $display("Queue filled up to %0d of %0d entries under long hold-off and random stalls.",
             max_fill, QDEPTH);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- fifo_queue_with_dump.f -----
hdl/fqd_pkg.sv
hdl/fqd_channels.sv
hdl/fifo_queue_with_dump.sv
bench/tb_top.sv
